FILE: design/url_percent_decoder_macros.svh
// Assertion macros shared by the URL percent decoder RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define UPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define UPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/upd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
// No dependencies; imported by every module of the decoder.
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int CMD_BYTES = 3;

    // One decoded step: up to three output bytes, the first in data[0].
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] data;
        logic [1:0]                count;
        logic                      last;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h46)) ||
            ((c >= 8'h61) && (c <= 8'h66));
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            v = c - 8'h30;
        end
        else if ((c >= 8'h41) && (c <= 8'h46)) begin
            v = c - 8'h37;
        end
        else if ((c >= 8'h61) && (c <= 8'h66)) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

FILE: design/url_percent_decoder.sv
// Top level of the URL percent decoder: front end, command queue and output sequencer.
// Depends on upd_pkg, upd_front, upd_fifo and upd_back.
//
// The decoder takes one byte of URL form text per beat and sustains one beat per cycle
// in both directions unless the queue is full or m_axis_tready is low: "%XY" with hex
// digits of either case becomes one byte, '+' becomes a space, and other bytes pass
// through. A beat that breaks an open escape produces up to three output beats, which
// leave the output register one per cycle while m_axis_tready is high; the command
// queue between front end and sequencer absorbs these bursts, and input stalls only
// once it is full. An escape still open on the tlast beat is flushed literally, with
// tlast on the final output beat. A decoded byte is written to the command queue when
// the beat that completes it is accepted, and goes out through the output register.
module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    upd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    upd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

FILE: design/upd_front.sv
// Front end of the URL percent decoder: accepts input beats, tracks an open escape
// and turns each beat into a command of zero to three output bytes. Uses upd_pkg.
`include "url_percent_decoder_macros.svh"

module upd_front
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       push,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_PCT   = 2'd1,
        PEND_DIGIT = 2'd2
    } pend_t;

    pend_t      state_reg;
    pend_t      state_next;
    logic [7:0] digit_reg;
    logic [7:0] digit_next;

    logic       accept;
    logic       run_idle;
    logic [1:0] pre_count;
    logic [7:0] pre0;
    logic [7:0] pre1;
    logic [7:0] idle_byte;
    logic       idle_hold;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign idle_byte = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    assign idle_hold = (in_byte == CH_PERCENT) && !in_last;

    always_comb
    begin
        state_next = state_reg;
        digit_next = digit_reg;
        cmd        = '0;
        cmd.last   = in_last;
        run_idle   = 1'b0;
        pre_count  = 2'd0;
        pre0       = 8'h00;
        pre1       = 8'h00;

        unique case (state_reg)
            PEND_PCT:
            begin
                if (is_hex(in_byte)) begin
                    if (in_last) begin
                        cmd.data[0] = CH_PERCENT;
                        cmd.data[1] = in_byte;
                        cmd.count   = 2'd2;
                        state_next  = PEND_NONE;
                    end
                    else begin
                        digit_next = in_byte;
                        state_next = PEND_DIGIT;
                    end
                end
                else begin
                    pre0      = CH_PERCENT;
                    pre_count = 2'd1;
                    run_idle  = 1'b1;
                end
            end
            PEND_DIGIT:
            begin
                if (is_hex(in_byte)) begin
                    cmd.data[0] = {hex_val(digit_reg), hex_val(in_byte)};
                    cmd.count   = 2'd1;
                    state_next  = PEND_NONE;
                end
                else begin
                    pre0      = CH_PERCENT;
                    pre1      = digit_reg;
                    pre_count = 2'd2;
                    run_idle  = 1'b1;
                end
            end
            default:
            begin
                run_idle = 1'b1;
            end
        endcase

        if (run_idle) begin
            cmd.data[0] = pre0;
            cmd.data[1] = pre1;
            if (idle_hold) begin
                state_next = PEND_PCT;
                cmd.count  = pre_count;
            end
            else begin
                state_next = PEND_NONE;
                cmd.count  = pre_count + 2'd1;
                case (pre_count)
                    2'd0:    cmd.data[0] = idle_byte;
                    2'd1:    cmd.data[1] = idle_byte;
                    default: cmd.data[2] = idle_byte;
                endcase
            end
        end
    end

    assign push = accept && (cmd.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= PEND_NONE;
            digit_reg <= 8'h00;
        end
        else if (accept) begin
            state_reg <= state_next;
            digit_reg <= digit_next;
        end
    end

    // A string always closes with nothing pending and at least one byte queued.
    `UPD_ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_last, state_reg == PEND_NONE, "escape left open after last beat")
    `UPD_ASSERT_IMP(a_last_pushes, clk, rst_n, accept && in_last, push, "last beat produced no output")
    `UPD_ASSERT_IMP(a_push_room, clk, rst_n, push, !q_full, "push into a full queue")

endmodule

FILE: design/upd_fifo.sv
// Short command queue between the decoder front end and the output sequencer.
// Uses upd_pkg for the command type.
`include "url_percent_decoder_macros.svh"

module upd_fifo
    import upd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `UPD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

FILE: design/upd_back.sv
// Output sequencer of the URL percent decoder: walks the bytes of the queue head
// into a registered output stage, one beat per cycle unless out_ready stalls it. Uses upd_pkg.
`include "url_percent_decoder_macros.svh"

module upd_back
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head_cmd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    logic       load_ok;
    logic       emit;
    logic       final_byte;
    logic [7:0] sel_byte;

    assign load_ok    = !valid_reg || out_ready;
    assign emit       = head_valid && load_ok;
    assign final_byte = (idx_reg == (head_cmd.count - 2'd1));
    assign pop        = emit && final_byte;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head_cmd.data[0];
            2'd1:    sel_byte = head_cmd.data[1];
            default: sel_byte = head_cmd.data[2];
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (emit) begin
            valid_next = 1'b1;
            idx_next   = final_byte ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            byte_reg <= sel_byte;
            last_reg <= final_byte && head_cmd.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

    // A command partly sent stays at the head until its last byte goes out.
    `UPD_ASSERT_IMP(a_mid_cmd_head, clk, rst_n, idx_reg != 2'd0, head_valid, "queue head lost mid-command")

endmodule
